[src/wth_pkg.sv]
// Shared types and constants for the word tokenizer and hash bucket block.
`timescale 1ns / 1ps
`default_nettype none

package wth_pkg;

    // Skip states of the tokenizer
    localparam logic [1:0] SKIP_NONE  = 2'd0;
    localparam logic [1:0] SKIP_LONG  = 2'd1;
    localparam logic [1:0] SKIP_DIGIT = 2'd2;

    // ASCII landmarks
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Word queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // Finished word: seeded 32-bit hash and its length
    typedef struct packed {
        logic [31:0] hash;
        logic [5:0]  len;
    } t_word;

    // Queue handshake between the tokenizer and the queue
    typedef struct packed {
        logic  push;
        t_word data;
    } t_push;

endpackage

`default_nettype wire

[src/wth_front.sv]
// Tokenizer front end: classifies bytes, runs the rotate-xor hash, emits finished words.
`timescale 1ns / 1ps
`default_nettype none

module wth_front #(
    parameter int unsigned MAX_WORD = 50
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output wth_pkg::t_push   o_push
);

    logic [31:0] r_hash, n_hash;
    logic [5:0]  r_count, n_count;
    logic [1:0]  r_skip, n_skip;

    logic        is_upper, is_lower, is_letter, is_digit, is_apos;
    logic [7:0]  lower_byte;
    logic [7:0]  count_x5;
    logic [4:0]  seed_rot;
    logic [63:0] seed_dbl;
    logic [31:0] seed;

    // Byte classification
    assign is_upper  = (i_text_byte >= wth_pkg::CH_UPPER_A) &&
                       (i_text_byte <= wth_pkg::CH_UPPER_Z);
    assign is_lower  = (i_text_byte >= wth_pkg::CH_LOWER_A) &&
                       (i_text_byte <= wth_pkg::CH_LOWER_Z);
    assign is_letter = is_upper || is_lower;
    assign is_digit  = (i_text_byte >= wth_pkg::CH_ZERO) &&
                       (i_text_byte <= wth_pkg::CH_NINE);
    assign is_apos   = (i_text_byte == wth_pkg::CH_APOS);
    assign lower_byte = is_upper ? (i_text_byte | wth_pkg::CASE_BIT) : i_text_byte;

    // Length seed: count rotated left by 5*count mod 32
    assign count_x5 = {r_count, 2'b00} + {2'b00, r_count};
    assign seed_rot = count_x5[4:0];
    assign seed_dbl = {26'd0, r_count, 26'd0, r_count} << seed_rot;
    assign seed     = seed_dbl[63:32];

    // Next-state logic of the tokenizer
    always_comb begin
        n_hash       = r_hash;
        n_count      = r_count;
        n_skip       = r_skip;
        o_push.push  = 1'b0;
        o_push.data.hash = seed ^ r_hash;
        o_push.data.len  = r_count;
        if (i_take) begin
            if (i_end_of_text) begin
                n_hash  = '0;
                n_count = '0;
                n_skip  = wth_pkg::SKIP_NONE;
            end else begin
                case (r_skip)
                    wth_pkg::SKIP_LONG: begin
                        if (!is_letter) begin
                            n_skip = wth_pkg::SKIP_NONE;
                        end
                    end
                    wth_pkg::SKIP_DIGIT: begin
                        if (!is_letter && !is_digit) begin
                            n_skip = wth_pkg::SKIP_NONE;
                        end
                    end
                    default: begin
                        if (is_letter || (is_apos && (r_count != '0))) begin
                            if (r_count >= 6'(MAX_WORD)) begin
                                n_hash  = '0;
                                n_count = '0;
                                n_skip  = wth_pkg::SKIP_LONG;
                            end else begin
                                n_hash  = {r_hash[26:0], r_hash[31:27]} ^ {24'd0, lower_byte};
                                n_count = r_count + 6'd1;
                            end
                        end else if (is_digit) begin
                            n_hash  = '0;
                            n_count = '0;
                            n_skip  = wth_pkg::SKIP_DIGIT;
                        end else if (r_count != '0) begin
                            o_push.push = 1'b1;
                            n_hash  = '0;
                            n_count = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= '0;
            r_count <= '0;
            r_skip  <= wth_pkg::SKIP_NONE;
        end else begin
            r_hash  <= n_hash;
            r_count <= n_count;
            r_skip  <= n_skip;
        end
    end

endmodule

`default_nettype wire

[src/wth_queue.sv]
// Short word queue that decouples the tokenizer from the modulo pipeline.
`timescale 1ns / 1ps
`default_nettype none

module wth_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire wth_pkg::t_push i_push,
    input  wire logic        i_pop,
    output wth_pkg::t_word   o_head,
    output logic             o_empty,
    output logic             o_full
);

    localparam int unsigned DEPTH = wth_pkg::QUEUE_DEPTH;
    localparam int unsigned AW    = $clog2(DEPTH);

    wth_pkg::t_word    r_mem [0:DEPTH-1];
    logic [AW-1:0]     r_wr, r_rd;
    logic [AW:0]       r_cnt;
    logic              do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push.push) - (AW+1)'(do_pop);
        end
    end

endmodule

`default_nettype wire

[src/wth_mod.sv]
// Back end: restoring modulo pipeline, one conditional subtract per stage.
`timescale 1ns / 1ps
`default_nettype none

module wth_mod #(
    parameter logic [31:0] BUCKETS = 32'd1000003
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire wth_pkg::t_word i_word,
    input  wire logic        i_stall,
    output logic             o_adv,
    output logic             o_valid,
    output logic [19:0]      o_bucket,
    output logic [5:0]       o_word_length
);

    // Bits to hold BUCKETS; one step per shift that keeps BUCKETS<<k below 2^32
    localparam int unsigned BW    = $clog2(33'(BUCKETS) + 33'd1);
    localparam int unsigned NSTEP = 33 - BW;

    logic [31:0] r_rem [0:NSTEP-1];
    logic [5:0]  r_len [0:NSTEP-1];
    logic        r_vld [0:NSTEP-1];

    // Whole pipeline moves unless the output register is full and stalled
    assign o_adv = !r_vld[NSTEP-1] || !i_stall;

    genvar s;
    generate
        for (s = 0; s < NSTEP; s++) begin : g_step
            localparam logic [63:0] SUB = 64'(BUCKETS) << (NSTEP - 1 - s);
            logic [31:0] rem_in, rem_out;
            logic [5:0]  len_in;
            logic        vld_in;

            if (s == 0) begin : g_first
                assign rem_in = i_word.hash;
                assign len_in = i_word.len;
                assign vld_in = i_in_valid;
            end else begin : g_next
                assign rem_in = r_rem[s-1];
                assign len_in = r_len[s-1];
                assign vld_in = r_vld[s-1];
            end

            // Conditional subtract of the shifted modulus
            assign rem_out = (rem_in >= SUB[31:0]) ? (rem_in - SUB[31:0]) : rem_in;

            always_ff @(posedge i_clk) begin
                if (o_adv) begin
                    r_rem[s] <= rem_out;
                    r_len[s] <= len_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (o_adv) begin
                    r_vld[s] <= vld_in;
                end
            end
        end
    endgenerate

    assign o_valid       = r_vld[NSTEP-1];
    assign o_bucket      = r_rem[NSTEP-1][19:0];
    assign o_word_length = r_len[NSTEP-1];

endmodule

`default_nettype wire

[src/word_tokenizer_hash_bucket.sv]
// Top level: tokenizer front end, word queue and modulo pipeline.
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+-----------------------------
//  text in | i_valid / o_stall                | in        | i_text_byte, i_end_of_text
//  words   | o_valid / i_stall                | out       | o_bucket, o_word_length
//
// One byte is taken every cycle while the word queue has room; the hash update is
// a single rotate and xor. A finished word leaves the queue into the modulo pipeline,
// 33 - clog2(BUCKETS+1) stages deep (13 at the default), the last stage being the output
// register. An output stall freezes the pipeline while that register holds a word; the
// queue then fills and o_stall rises. Synchronous reset clears control and hash state.
`timescale 1ns / 1ps
`default_nettype none

module word_tokenizer_hash_bucket #(
    parameter int unsigned MAX_WORD = 50,
    parameter logic [31:0] BUCKETS  = 32'd1000003
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [19:0]      o_bucket,
    output logic [5:0]       o_word_length
);

    wth_pkg::t_push push;
    wth_pkg::t_word head;
    logic           q_empty, q_full, adv, take;

    // Input transaction accepted when the queue can take a word
    assign o_stall = q_full;
    assign take    = i_valid && !q_full;

    wth_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push)
    );

    wth_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (adv),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    wth_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (!q_empty),
        .i_word        (head),
        .i_stall       (i_stall),
        .o_adv         (adv),
        .o_valid       (o_valid),
        .o_bucket      (o_bucket),
        .o_word_length (o_word_length)
    );

endmodule

`default_nettype wire
